// ===== rtl/glo_pkg.sv =====
// shared types and constants of the group lasso objective core
package glo_pkg;

    // action codes carried in tuser
    localparam logic [2:0] ACT_LOAD_Y  = 3'd0;
    localparam logic [2:0] ACT_LOAD_H  = 3'd1;
    localparam logic [2:0] ACT_LOAD_X  = 3'd2;
    localparam logic [2:0] ACT_LOAD_W  = 3'd3;
    localparam logic [2:0] ACT_LOAD_V  = 3'd4;
    localparam logic [2:0] ACT_LOAD_GW = 3'd5;
    localparam logic [2:0] ACT_COMPUTE = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_ETA      = 3'd0;
    localparam logic [2:0] CFG_GAMMA    = 3'd1;
    localparam logic [2:0] CFG_SAMPLES  = 3'd2;
    localparam logic [2:0] CFG_INNER    = 3'd3;
    localparam logic [2:0] CFG_FEATURES = 3'd4;
    localparam logic [2:0] CFG_RESPONSE = 3'd5;
    localparam logic [2:0] CFG_GROUPS   = 3'd6;

    // shared multiplier geometry
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 64;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [62:0] OUT_MAX = {63{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT,
        ST_DOT_DRAIN,
        ST_SHIFT,
        ST_NRM_ISSUE,
        ST_NRM_WAIT,
        ST_MUL,
        ST_GAMMA,
        ST_GAMMA_WAIT,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/glo_sqrt.sv =====
// digit-by-digit floor square root, two radicand bits per cycle
module glo_sqrt #(
    parameter int RAD_W = 72
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_W-1:0]     radicand,
    output logic                 done,
    output logic [RAD_W/2-1:0]   root
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;

    assign rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/glo_mul.sv =====
// unsigned 32 x 64 multiplier built from two 32 x 32 partial products
module glo_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [glo_pkg::MUL_A_W-1:0]   a,
    input  logic [glo_pkg::MUL_B_W-1:0]   b,
    output logic                          done,
    output logic [glo_pkg::MUL_P_W-1:0]   prod
);
    import glo_pkg::*;

    localparam int HALF = MUL_B_W / 2;

    logic [1:0]              step_reg;
    logic                    done_reg;
    logic [MUL_A_W-1:0]      a_reg;
    logic [MUL_B_W-1:0]      b_reg;
    logic [MUL_A_W+HALF-1:0] pp_reg;
    logic [MUL_A_W+HALF-1:0] lo_reg;
    logic [MUL_P_W-1:0]      prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                step_reg <= 2'd1;
            else if (step_reg == 2'd1)
                step_reg <= 2'd2;
            else if (step_reg == 2'd2)
                step_reg <= 2'd3;
            else if (step_reg == 2'd3)
            begin
                step_reg <= 2'd0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (step_reg == 2'd1)
            pp_reg <= a_reg * b_reg[HALF-1:0];
        if (step_reg == 2'd2)
        begin
            lo_reg <= pp_reg;
            pp_reg <= a_reg * b_reg[MUL_B_W-1:HALF];
        end
        if (step_reg == 2'd3)
            prod_reg <= {pp_reg, {HALF{1'b0}}} + MUL_P_W'(lo_reg);
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== rtl/group_lasso_objective_core.sv =====
// top level: stores, sequencer and datapath of the group lasso objective core
// loads are accepted back to back in idle
// each store has a single read port and the root is computed serially
// one compute in flight; the next item is taken once the result sits in the
//   output register
// reset clears control, eta and gamma, sets dims to 16; stores hold garbage until loaded
module group_lasso_objective_core #(
    parameter int MAX_DIM    = 16,
    parameter int VALUE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // row_index[3:0], col_index[7:4], element_value[39:8]
    input  logic [2:0]  s_axis_tuser,   // action[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // objective_value[62:0], zero fill[63]
    output logic [0:0]  m_axis_tuser,   // saturated[0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_wdata
);
    import glo_pkg::*;

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W  = 2 * VALUE_BITS + IDX_W + 1;
    localparam int SQ_W   = 2 * VALUE_BITS + IDX_W;
    localparam int RAD_W  = SQ_W + (SQ_W % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int MAG_W  = VALUE_BITS + 1;
    localparam int SUM_W  = 2 * MAG_W + 2 * IDX_W;

    // state held in synchronous stores, read data registered
    logic [VALUE_BITS-1:0] y_mem  [DEPTH];
    logic [VALUE_BITS-1:0] h_mem  [DEPTH];
    logic [VALUE_BITS-1:0] x_mem  [DEPTH];
    logic [VALUE_BITS-1:0] w_mem  [DEPTH];
    logic [VALUE_BITS-1:0] v_mem  [DEPTH];
    logic [VALUE_BITS-1:0] hx_mem [DEPTH];
    logic [VALUE_BITS-1:0] gw_mem [MAX_DIM];

    logic signed [VALUE_BITS-1:0] y_rd_reg, h_rd_reg, x_rd_reg, w_rd_reg;
    logic signed [VALUE_BITS-1:0] v_rd_reg, hx_rd_reg, gw_rd_reg;

    // configuration registers
    logic [30:0] eta_reg, gamma_reg;
    logic [4:0]  samples_reg, inner_reg, features_reg, response_reg, groups_reg;
    logic [DIM_W-1:0] dim_m, dim_k, dim_f, dim_c, dim_g;

    // sequencer
    state_t state_reg, state_next;
    logic [IDX_W-1:0] ci_reg, cj_reg, ct_reg, ci_next, cj_next, ct_next;
    logic res_phase_reg, res_phase_next;
    logic norm_v_reg, norm_v_next;
    logic [62:0] total_reg, total_next;
    logic signed [63:0] s_sum_reg, s_sum_next;
    logic sat_reg, sat_next;

    // pipeline
    logic s1_valid_reg, s1_first_reg, s1_last_reg, s1_zero_reg;
    logic s2_valid_reg, s2_first_reg, s2_last_reg;
    logic s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic [ADDR_W-1:0] s1_ij_reg, s2_ij_reg, s3_ij_reg;
    logic signed [2*VALUE_BITS-1:0] prod_reg;
    logic signed [ACC_W-1:0] dot_acc_reg;
    logic [RAD_W-1:0] sq_acc_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [2*MAG_W-1:0] sq_reg;
    logic [SUM_W-1:0] res_sum_reg;

    // output register
    logic        out_valid_reg;
    logic [62:0] out_value_reg;
    logic        out_sat_reg;
    logic        out_load;

    // input fields
    logic        in_acc;
    logic [2:0]  act;
    logic [3:0]  ld_row, ld_col;
    logic [VALUE_BITS-1:0] ld_val;
    logic        ld_ok;
    logic [ADDR_W-1:0] ld_addr;

    function automatic logic [ADDR_W-1:0] cell_addr(input int r, input int c);
        return ADDR_W'(r * MAX_DIM + c);
    endfunction

    function automatic logic [DIM_W-1:0] cap_dim(input logic [4:0] v);
        return (int'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(v);
    endfunction

    assign dim_m = cap_dim(samples_reg);
    assign dim_k = cap_dim(inner_reg);
    assign dim_f = cap_dim(features_reg);
    assign dim_c = cap_dim(response_reg);
    assign dim_g = cap_dim(groups_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc  = s_axis_tvalid & s_axis_tready;
    assign act     = s_axis_tuser;
    assign ld_row  = s_axis_tdata[3:0];
    assign ld_col  = s_axis_tdata[7:4];
    assign ld_val  = s_axis_tdata[8 +: VALUE_BITS];
    assign ld_ok   = (int'(ld_row) < MAX_DIM) && (int'(ld_col) < MAX_DIM);
    assign ld_addr = cell_addr(int'(ld_row), int'(ld_col));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_reg      <= '0;
            gamma_reg    <= '0;
            samples_reg  <= 5'd16;
            inner_reg    <= 5'd16;
            features_reg <= 5'd16;
            response_reg <= 5'd16;
            groups_reg   <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ETA:      eta_reg      <= cfg_wdata;
                CFG_GAMMA:    gamma_reg    <= cfg_wdata;
                CFG_SAMPLES:  samples_reg  <= cfg_wdata[4:0];
                CFG_INNER:    inner_reg    <= cfg_wdata[4:0];
                CFG_FEATURES: features_reg <= cfg_wdata[4:0];
                CFG_RESPONSE: response_reg <= cfg_wdata[4:0];
                CFG_GROUPS:   groups_reg   <= cfg_wdata[4:0];
                default:      ;
            endcase
        end
    end

    // loop bookkeeping shared by the two combinational blocks
    logic is_norm;
    logic [DIM_W-1:0] cur_len, outer_j, rows;
    logic t_last, j_last, i_last, row_last, outer_ok, rows_ok, pipe_empty;

    assign is_norm  = (state_reg == ST_NRM_ISSUE) || (state_reg == ST_NRM_WAIT)
                   || (state_reg == ST_MUL);
    assign cur_len  = (state_reg == ST_NRM_ISSUE) ? dim_c : (res_phase_reg ? dim_f : dim_k);
    assign outer_j  = res_phase_reg ? dim_c : dim_f;
    assign rows     = norm_v_reg ? dim_g : dim_f;
    assign t_last   = (cur_len == '0) || (DIM_W'(ct_reg) + 1'b1 == cur_len);
    assign j_last   = (DIM_W'(cj_reg) + 1'b1 == outer_j);
    assign i_last   = (DIM_W'(ci_reg) + 1'b1 == dim_m);
    assign row_last = (DIM_W'(ci_reg) + 1'b1 == rows);
    assign outer_ok = (dim_m != '0) && (outer_j != '0);
    assign rows_ok  = (rows != '0);
    assign pipe_empty = !(s1_valid_reg | s2_valid_reg | s3_valid_reg
                        | s4_valid_reg | s5_valid_reg);

    // store addresses; norm walks read rows, dot products walk row by column
    logic [ADDR_W-1:0] addr_it, addr_tj, addr_ij;
    assign addr_it = cell_addr(int'(ci_reg), int'(ct_reg));
    assign addr_tj = cell_addr(int'(ct_reg), int'(cj_reg));
    assign addr_ij = cell_addr(int'(ci_reg), int'(cj_reg));

    logic hx_we;
    logic signed [VALUE_BITS-1:0] clamp_val;

    always_ff @(posedge clk)
    begin
        if (in_acc && ld_ok)
        begin
            unique case (act)
                ACT_LOAD_Y: y_mem[ld_addr] <= ld_val;
                ACT_LOAD_H: h_mem[ld_addr] <= ld_val;
                ACT_LOAD_X: x_mem[ld_addr] <= ld_val;
                ACT_LOAD_W: w_mem[ld_addr] <= ld_val;
                ACT_LOAD_V: v_mem[ld_addr] <= ld_val;
                default:    ;
            endcase
        end
        if (in_acc && act == ACT_LOAD_GW && int'(ld_row) < MAX_DIM)
            gw_mem[IDX_W'(ld_row)] <= ld_val;
        if (hx_we)
            hx_mem[s3_ij_reg] <= clamp_val;

        h_rd_reg  <= h_mem[addr_it];
        x_rd_reg  <= x_mem[addr_tj];
        hx_rd_reg <= hx_mem[addr_it];
        w_rd_reg  <= w_mem[is_norm ? addr_it : addr_tj];
        v_rd_reg  <= v_mem[addr_it];
        gw_rd_reg <= gw_mem[ci_reg];
        y_rd_reg  <= y_mem[s2_ij_reg];
    end

    // issue strobes from the sequencer
    logic iss_valid, iss_first, iss_zero;

    // operand select: dot products pair two stores, norms square one
    logic signed [VALUE_BITS-1:0] op_a, op_b;
    always_comb
    begin
        if (is_norm)
            op_a = norm_v_reg ? v_rd_reg : w_rd_reg;
        else
            op_a = res_phase_reg ? hx_rd_reg : h_rd_reg;
        if (is_norm)
            op_b = op_a;
        else
            op_b = res_phase_reg ? w_rd_reg : x_rd_reg;
    end

    // stage 3 clamp and residual
    logic signed [ACC_W-1:0] vmax_a, vmin_a;
    logic clamp_hit;
    logic signed [VALUE_BITS:0] diff;
    logic st3_dot;

    assign vmax_a = ACC_W'({1'b0, {(VALUE_BITS-1){1'b1}}});
    assign vmin_a = ~vmax_a;
    assign st3_dot = s3_valid_reg & !is_norm;

    always_comb
    begin
        clamp_hit = 1'b0;
        clamp_val = dot_acc_reg[VALUE_BITS-1:0];
        if (dot_acc_reg > vmax_a)
        begin
            clamp_hit = 1'b1;
            clamp_val = vmax_a[VALUE_BITS-1:0];
        end
        else if (dot_acc_reg < vmin_a)
        begin
            clamp_hit = 1'b1;
            clamp_val = vmin_a[VALUE_BITS-1:0];
        end
    end

    assign hx_we = st3_dot & !res_phase_reg;
    assign diff  = {y_rd_reg[VALUE_BITS-1], y_rd_reg} - {clamp_val[VALUE_BITS-1], clamp_val};

    // datapath pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= iss_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg & s2_last_reg;
            s4_valid_reg <= st3_dot & res_phase_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= iss_first;
        s1_last_reg  <= t_last;
        s1_zero_reg  <= iss_zero;
        s1_ij_reg    <= addr_ij;

        // signed product kept apart from the zero select so the operands sign extend
        if (s1_zero_reg)
            prod_reg <= '0;
        else
            prod_reg <= op_a * op_b;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_ij_reg    <= s1_ij_reg;

        if (s2_valid_reg)
        begin
            if (is_norm)
                sq_acc_reg <= (s2_first_reg ? '0 : sq_acc_reg)
                            + RAD_W'($unsigned(prod_reg));
            else
                dot_acc_reg <= (s2_first_reg ? '0 : dot_acc_reg)
                             + ACC_W'(prod_reg >>> FRAC_BITS);
        end
        s3_ij_reg <= s2_ij_reg;

        mag_reg <= diff[VALUE_BITS] ? MAG_W'(-diff) : MAG_W'(diff);
        sq_reg  <= mag_reg * mag_reg;

        if (state_reg == ST_IDLE)
            res_sum_reg <= '0;
        else if (s5_valid_reg)
            res_sum_reg <= res_sum_reg + SUM_W'(sq_reg);
    end

    // serial root and shared multiplier
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic              mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;

    glo_sqrt #(.RAD_W(RAD_W)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s3_valid_reg & is_norm),
        .radicand (sq_acc_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    glo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // product floored to the fraction point and clamped to the output range
    logic [MUL_P_W-1:0] mq_full;
    logic               mq_sat;
    logic [62:0]        mq;
    assign mq_full = mul_prod >> FRAC_BITS;
    assign mq_sat  = |mq_full[MUL_P_W-1:63];
    assign mq      = mq_sat ? OUT_MAX : mq_full[62:0];

    // residual sum scaled by one half and the fraction point
    logic [SUM_W+63:0] res_ext;
    logic              res_over;
    assign res_ext  = (SUM_W+64)'(res_sum_reg >> (FRAC_BITS + 1));
    assign res_over = res_ext > (SUM_W+64)'(OUT_MAX);

    // saturating add of a term to the running total
    logic [63:0] add_sum;
    logic [62:0] add_term;
    assign add_sum = {1'b0, total_reg} + {1'b0, add_term};

    logic [VALUE_BITS-1:0] gw_mag;
    logic [63:0]           g_mag;
    logic signed [63:0]    p_s, out_max_s;
    assign gw_mag    = gw_rd_reg[VALUE_BITS-1] ? VALUE_BITS'(-gw_rd_reg)
                                               : VALUE_BITS'(gw_rd_reg);
    assign g_mag     = s_sum_reg[63] ? 64'(-s_sum_reg) : 64'(s_sum_reg);
    assign p_s       = $signed({1'b0, mq});
    assign out_max_s = $signed({1'b0, OUT_MAX});
    assign add_term  = mq;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc && act == ACT_COMPUTE)
                    state_next = ST_DOT;
            ST_DOT:
                if (!outer_ok || (t_last && j_last && i_last))
                    state_next = ST_DOT_DRAIN;
            ST_DOT_DRAIN:
                if (pipe_empty)
                    state_next = res_phase_reg ? ST_SHIFT : ST_DOT;
            ST_SHIFT:
                state_next = ST_NRM_ISSUE;
            ST_NRM_ISSUE:
                if (rows_ok)
                begin
                    if (t_last)
                        state_next = ST_NRM_WAIT;
                end
                else if (norm_v_reg)
                    state_next = ST_GAMMA;
            ST_NRM_WAIT:
                if (sqrt_done)
                    state_next = ST_MUL;
            ST_MUL:
                if (mul_done)
                    state_next = (row_last && norm_v_reg) ? ST_GAMMA : ST_NRM_ISSUE;
            ST_GAMMA:
                state_next = ST_GAMMA_WAIT;
            ST_GAMMA_WAIT:
                if (mul_done)
                    state_next = ST_FINISH;
            ST_FINISH:
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and accumulators
    always_comb
    begin
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        ct_next        = ct_reg;
        res_phase_next = res_phase_reg;
        norm_v_next    = norm_v_reg;
        total_next     = total_reg;
        s_sum_next     = s_sum_reg;
        sat_next       = sat_reg | (st3_dot & clamp_hit);
        iss_valid      = 1'b0;
        iss_first      = (ct_reg == '0);
        iss_zero       = (cur_len == '0);
        mul_start      = 1'b0;
        mul_a          = MUL_A_W'(eta_reg);
        mul_b          = MUL_B_W'(sqrt_root);
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc && act == ACT_COMPUTE)
                begin
                    ci_next        = '0;
                    cj_next        = '0;
                    ct_next        = '0;
                    res_phase_next = 1'b0;
                    norm_v_next    = 1'b0;
                    total_next     = '0;
                    s_sum_next     = '0;
                    sat_next       = 1'b0;
                end
            ST_DOT:
                if (outer_ok)
                begin
                    iss_valid = 1'b1;
                    if (t_last)
                    begin
                        ct_next = '0;
                        if (j_last)
                        begin
                            cj_next = '0;
                            ci_next = i_last ? '0 : ci_reg + 1'b1;
                        end
                        else
                            cj_next = cj_reg + 1'b1;
                    end
                    else
                        ct_next = ct_reg + 1'b1;
                end
            ST_DOT_DRAIN:
                if (pipe_empty && !res_phase_reg)
                begin
                    res_phase_next = 1'b1;
                    ci_next        = '0;
                    cj_next        = '0;
                    ct_next        = '0;
                end
            ST_SHIFT:
            begin
                ci_next = '0;
                ct_next = '0;
                if (res_over)
                begin
                    total_next = OUT_MAX;
                    sat_next   = 1'b1;
                end
                else
                    total_next = res_ext[62:0];
            end
            ST_NRM_ISSUE:
                if (rows_ok)
                begin
                    iss_valid = 1'b1;
                    ct_next   = t_last ? '0 : ct_reg + 1'b1;
                end
                else if (!norm_v_reg)
                begin
                    norm_v_next = 1'b1;
                    ci_next     = '0;
                end
            ST_NRM_WAIT:
                if (sqrt_done)
                begin
                    mul_start = 1'b1;
                    mul_a     = norm_v_reg ? MUL_A_W'(gw_mag) : MUL_A_W'(eta_reg);
                end
            ST_MUL:
                if (mul_done)
                begin
                    sat_next = sat_next | mq_sat;
                    if (!norm_v_reg)
                    begin
                        // eta term straight into the total
                        if (add_sum[63])
                        begin
                            total_next = OUT_MAX;
                            sat_next   = 1'b1;
                        end
                        else
                            total_next = add_sum[62:0];
                    end
                    else if (gw_rd_reg[VALUE_BITS-1])
                    begin
                        // negative row weight subtracts, floor at minus full scale
                        if (s_sum_reg < p_s - out_max_s)
                        begin
                            s_sum_next = -out_max_s;
                            sat_next   = 1'b1;
                        end
                        else
                            s_sum_next = s_sum_reg - p_s;
                    end
                    else
                    begin
                        if (s_sum_reg > out_max_s - p_s)
                        begin
                            s_sum_next = out_max_s;
                            sat_next   = 1'b1;
                        end
                        else
                            s_sum_next = s_sum_reg + p_s;
                    end
                    if (row_last)
                    begin
                        ci_next     = '0;
                        norm_v_next = 1'b1;
                    end
                    else
                        ci_next = ci_reg + 1'b1;
                end
            ST_GAMMA:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(gamma_reg);
                mul_b     = g_mag;
            end
            ST_GAMMA_WAIT:
                if (mul_done)
                begin
                    sat_next = sat_next | mq_sat;
                    if (!s_sum_reg[63])
                    begin
                        if (add_sum[63])
                        begin
                            total_next = OUT_MAX;
                            sat_next   = 1'b1;
                        end
                        else
                            total_next = add_sum[62:0];
                    end
                    else if (mq > total_reg)
                    begin
                        total_next = '0;
                        sat_next   = 1'b1;
                    end
                    else
                        total_next = total_reg - mq;
                end
            ST_FINISH:
                if (!out_valid_reg || m_axis_tready)
                    out_load = 1'b1;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ci_reg        <= '0;
            cj_reg        <= '0;
            ct_reg        <= '0;
            res_phase_reg <= 1'b0;
            norm_v_reg    <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ci_reg        <= ci_next;
            cj_reg        <= cj_next;
            ct_reg        <= ct_next;
            res_phase_reg <= res_phase_next;
            norm_v_reg    <= norm_v_next;
            sat_reg       <= sat_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        s_sum_reg <= s_sum_next;
        if (out_load)
        begin
            out_value_reg <= total_reg;
            out_sat_reg   <= sat_reg;
        end
    end

    // result transaction
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_value_reg};
    assign m_axis_tuser  = out_sat_reg;

endmodule

// ===== tb/sv/tb_group_lasso_objective_core.sv =====
// testbench of the group lasso objective core: stores loaded, objective predicted and checked
module tb_group_lasso_objective_core;
    import glo_pkg::*;

    localparam int  STEP_LIMIT = 20_000_000;
    localparam int  SETTLE     = 80;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // row_index[3:0], col_index[7:4], element_value[39:8]
    logic [2:0]  s_axis_tuser;   // action[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // objective_value[62:0], zero fill[63]
    logic [0:0]  m_axis_tuser;   // saturated[0]
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [30:0] cfg_wdata;

    group_lasso_objective_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    typedef struct {
        bit [62:0] value;
        bit        sat;
    } objective_t;

    // predicts the objective on each compute transaction and holds the open ones
    class objective_scoreboard;
        longint     mat[5][256];   // y, h, x, w, v indexed by load action
        longint     row_wt[16];
        bit [30:0]  eta;
        bit [30:0]  gam;
        bit [4:0]   dims[2:6];     // indexed by register index
        bit         clamped;
        objective_t pending[$];
        int         errors;

        function new();
            eta = 0;
            gam = 0;
            for (int i = 2; i <= 6; i++)
                dims[i] = 5'd16;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void set_reg(bit [2:0] idx, bit [30:0] val);
            case (idx)
                CFG_ETA:   eta = val;
                CFG_GAMMA: gam = val;
                CFG_SAMPLES, CFG_INNER, CFG_FEATURES, CFG_RESPONSE, CFG_GROUPS:
                    dims[idx] = val[4:0];
                default: ;
            endcase
        endfunction

        function int eff_dim(bit [2:0] idx);
            return (dims[idx] > 16) ? 16 : int'(dims[idx]);
        endfunction

        // clamp to the signed 32-bit range
        function longint clamp32(longint v);
            if (v > 64'sd2147483647) begin clamped = 1; return 64'sd2147483647; end
            if (v < -64'sd2147483648) begin clamped = 1; return -64'sd2147483648; end
            return v;
        endfunction

        function bit [63:0] shr_sat(bit [127:0] v, int sh);
            bit [127:0] q;
            q = v >> sh;
            if (q > {65'd0, OUT_MAX}) begin clamped = 1; return {1'b0, OUT_MAX}; end
            return q[63:0];
        endfunction

        function bit [63:0] mulq(bit [63:0] a, bit [63:0] b);
            bit [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return shr_sat(p, 16);
        endfunction

        function bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
            bit [63:0] s;
            s = a + b;
            if (s > {1'b0, OUT_MAX}) begin clamped = 1; return {1'b0, OUT_MAX}; end
            return s;
        endfunction

        // floor root of the exact sum of squares of one row
        function bit [63:0] row_norm(int kind, int row, int n);
            bit [127:0] acc;
            bit [63:0]  root;
            bit [63:0]  cand;
            longint     e;
            acc = 0;
            for (int j = 0; j < n; j++) begin
                e = mat[kind][row * 16 + j];
                if (e < 0) e = -e;
                acc += {64'd0, e} * {64'd0, e};
            end
            root = 0;
            for (int b = 35; b >= 0; b--) begin
                cand = root | (64'd1 << b);
                if ({64'd0, cand} * {64'd0, cand} <= acc) root = cand;
            end
            return root;
        endfunction

        function objective_t objective();
            objective_t r;
            longint     hx[256];
            longint     acc, d, wv, grp_sum;
            bit [127:0] sq;
            bit [63:0]  total, p, t3, gmag;
            int         m, k, f, c, g;
            clamped = 0;
            m = eff_dim(CFG_SAMPLES);
            k = eff_dim(CFG_INNER);
            f = eff_dim(CFG_FEATURES);
            c = eff_dim(CFG_RESPONSE);
            g = eff_dim(CFG_GROUPS);
            for (int i = 0; i < m; i++)
                for (int j = 0; j < f; j++) begin
                    acc = 0;
                    for (int t = 0; t < k; t++)
                        acc += (mat[ACT_LOAD_H][i*16+t] * mat[ACT_LOAD_X][t*16+j]) >>> 16;
                    hx[i*16+j] = clamp32(acc);
                end
            sq = 0;
            for (int i = 0; i < m; i++)
                for (int j = 0; j < c; j++) begin
                    acc = 0;
                    for (int t = 0; t < f; t++)
                        acc += (hx[i*16+t] * mat[ACT_LOAD_W][t*16+j]) >>> 16;
                    acc = clamp32(acc);
                    d = mat[ACT_LOAD_Y][i*16+j] - acc;
                    if (d < 0) d = -d;
                    sq += {64'd0, d} * {64'd0, d};
                end
            // half the squared residual norm
            total = shr_sat(sq, 17);
            for (int j = 0; j < f; j++)
                total = add_sat(total, mulq({33'd0, eta}, row_norm(ACT_LOAD_W, j, c)));
            // signed weighted sum of V row norms, held within +-OUT_MAX
            grp_sum = 0;
            for (int i = 0; i < g; i++) begin
                wv = row_wt[i];
                p = mulq((wv < 0) ? -wv : wv, row_norm(ACT_LOAD_V, i, c));
                if (wv < 0) begin
                    if (grp_sum < -longint'(OUT_MAX) + longint'(p)) begin
                        grp_sum = -longint'(OUT_MAX);
                        clamped = 1;
                    end else
                        grp_sum -= longint'(p);
                end else begin
                    if (grp_sum > longint'(OUT_MAX) - longint'(p)) begin
                        grp_sum = longint'(OUT_MAX);
                        clamped = 1;
                    end else
                        grp_sum += longint'(p);
                end
            end
            gmag = (grp_sum < 0) ? -grp_sum : grp_sum;
            t3 = mulq({33'd0, gam}, gmag);
            if (grp_sum >= 0)
                total = add_sat(total, t3);
            else if (t3 > total) begin
                clamped = 1;
                total = 0;
            end else
                total = total - t3;
            r.value = total[62:0];
            r.sat   = clamped;
            return r;
        endfunction

        // accepted input transaction: update the stores or queue a prediction
        function void note_item(bit [2:0] act, bit [3:0] row, bit [3:0] col, bit [31:0] val);
            case (act)
                ACT_COMPUTE: pending.push_back(objective());
                ACT_LOAD_GW: row_wt[row] = longint'(signed'(val));
                ACT_LOAD_Y, ACT_LOAD_H, ACT_LOAD_X, ACT_LOAD_W, ACT_LOAD_V:
                    mat[act][row * 16 + col] = longint'(signed'(val));
                default: ;
            endcase
        endfunction

        task check_result(bit [62:0] value, bit sat);
            objective_t exp_r;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %0d sat %0d", value, sat));
                return;
            end
            exp_r = pending.pop_front();
            if (value !== exp_r.value)
                report($sformatf("objective %0d, predicted %0d", value, exp_r.value));
            if (sat !== exp_r.sat)
                report($sformatf("saturated %0d, predicted %0d", sat, exp_r.sat));
        endtask
    endclass

    objective_scoreboard sb;
    bit  tx_idles;
    bit  rx_idles;
    int  cycles;

    // clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle counter with a generous timeout
    always @(posedge clk) begin
        cycles++;
        if (cycles > STEP_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // monitors sample both streams at the rising edge
    always @(posedge clk) begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_item(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[7:4],
                         s_axis_tdata[39:8]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[62:0], m_axis_tuser[0]);
    end

    // receiver: random stall bursts while rx_idles is set
    initial begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (rx_idles && $urandom_range(0, 9) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // one input transaction; valid stays high so back-to-back items need no gap
    task automatic push_item(bit [2:0] act, bit [3:0] row, bit [3:0] col, bit [31:0] val);
        if (tx_idles && $urandom_range(0, 6) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {val, col, row};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // sender holds off until every predicted result is back and the core is quiet
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    // register write, only called while drained
    task automatic write_reg(bit [2:0] idx, bit [30:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // dimension value with random upper bits; mostly small so computes stay short
    function automatic bit [30:0] dim_word(int d);
        bit [30:0] w;
        w = 31'($urandom);
        w[4:0] = 5'(d);
        return w;
    endfunction

    function automatic int pick_dim();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
        return $urandom_range(0, 31);
    endfunction

    function automatic bit [30:0] pick_weight();
        case ($urandom_range(0, 4))
            0: return 31'd0;
            1: return 31'h7fffffff;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 1 << 18));
        endcase
    endfunction

    function automatic bit [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            3: return 32'(signed'($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return 32'(signed'($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    task automatic set_dims(int d);
        for (int i = CFG_SAMPLES; i <= CFG_GROUPS; i++)
            write_reg(3'(i), dim_word(d));
    endtask

    initial begin
        bit [2:0] act;
        sb = new();
        tx_idles      = 1'b1;
        rx_idles      = 1'b1;
        cycles        = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every store entry so no compute reads an unwritten one
        for (int a = ACT_LOAD_Y; a <= ACT_LOAD_V; a++)
            for (int e = 0; e < 256; e++)
                push_item(3'(a), 4'(e / 16), 4'(e % 16),
                          32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17)));
        for (int r = 0; r < 16; r++)
            push_item(ACT_LOAD_GW, 4'(r), 4'($urandom), 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17)));

        // directed: reset settings, full dimensions
        push_item(ACT_COMPUTE, 4'd0, 4'd0, 32'd0);
        drain();
        write_reg(CFG_ETA, 31'h7fffffff);
        write_reg(CFG_GAMMA, 31'h7fffffff);
        push_item(ACT_COMPUTE, 4'd15, 4'd15, 32'hffffffff);
        // field extremes, ignored action, then compute
        push_item(ACT_LOAD_Y, 4'd0, 4'd0, 32'h7fffffff);
        push_item(ACT_LOAD_H, 4'd15, 4'd15, 32'h80000000);
        push_item(ACT_LOAD_X, 4'd0, 4'd15, 32'h80000000);
        push_item(ACT_LOAD_W, 4'd15, 4'd0, 32'h7fffffff);
        push_item(ACT_LOAD_V, 4'd15, 4'd15, 32'h80000000);
        push_item(ACT_LOAD_GW, 4'd15, 4'd9, 32'h80000000);
        push_item(3'd7, 4'd5, 4'd5, 32'h12345678);
        push_item(ACT_COMPUTE, 4'd0, 4'd0, 32'd0);
        drain();
        // empty dimensions: all sums vanish
        set_dims(0);
        push_item(ACT_COMPUTE, 4'd0, 4'd0, 32'd0);
        drain();
        // dimensions above the store size act as the full size
        write_reg(CFG_ETA, 31'd3);
        write_reg(CFG_GAMMA, 31'd5);
        set_dims(31);
        push_item(ACT_COMPUTE, 4'd0, 4'd0, 32'd0);
        drain();
        // negative weighted term larger than the rest: total clamps at zero
        set_dims(1);
        write_reg(CFG_ETA, 31'd0);
        write_reg(CFG_GAMMA, 31'h7fffffff);
        push_item(ACT_LOAD_Y, 4'd0, 4'd0, 32'd0);
        push_item(ACT_LOAD_H, 4'd0, 4'd0, 32'd0);
        push_item(ACT_LOAD_GW, 4'd0, 4'd0, 32'hff9c0000);
        push_item(ACT_LOAD_V, 4'd0, 4'd0, 32'h7fffffff);
        push_item(ACT_COMPUTE, 4'd0, 4'd0, 32'd0);

        // random phases: new settings while drained, then mixed loads and computes
        for (int ph = 0; ph < 13; ph++) begin
            drain();
            if (ph >= 10) begin
                tx_idles = 1'b0;
                rx_idles = 1'b0;
            end
            write_reg(CFG_ETA, pick_weight());
            write_reg(CFG_GAMMA, pick_weight());
            for (int i = CFG_SAMPLES; i <= CFG_GROUPS; i++)
                write_reg(3'(i), dim_word(pick_dim()));
            repeat ($urandom_range(16, 24)) begin
                case ($urandom_range(0, 11))
                    0, 1, 2: act = ACT_COMPUTE;
                    3:       act = 3'd7;
                    4:       act = ACT_LOAD_GW;
                    default: act = 3'($urandom_range(0, 4));
                endcase
                push_item(act, 4'($urandom), 4'($urandom), pick_value());
            end
        end

        drain();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
